/* rtl/v3au_pkg.sv */
// shared types, constants and arithmetic helpers for the vector arithmetic unit
package v3au_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DW         = 32;
  localparam int QW         = DW + FRAC_BITS;
  localparam int ROOT_STEPS = 32;

  typedef enum logic [3:0] {
    MODE_ADD   = 4'd0,
    MODE_SUB   = 4'd1,
    MODE_SCALE = 4'd2,
    MODE_DIV   = 4'd3,
    MODE_NORM  = 4'd4,
    MODE_DOT   = 4'd5,
    MODE_LEN   = 4'd6,
    MODE_LEN2  = 4'd7,
    MODE_DIST  = 4'd8,
    MODE_DIST2 = 4'd9
  } mode_t;

  typedef struct packed {
    logic        ov;
    logic [31:0] val;
  } sat_t;

  // fields that travel with an item through the whole pipeline
  typedef struct packed {
    mode_t           mode;
    logic [2:0][31:0] res;
    logic [31:0]     scl;
    logic            ov;
    logic            dz;
    logic [2:0][31:0] nmag;
    logic [2:0]      nneg;
    logic [31:0]     smag;
    logic            sneg;
    logic [31:0]     root;
  } carry_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // saturate a 33-bit signed sum or difference
  function automatic sat_t sat_sum(input logic [32:0] t);
    sat_t s;
    if (t[32] != t[31]) begin
      s.ov  = 1'b1;
      s.val = t[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      s.ov  = 1'b0;
      s.val = t[31:0];
    end
    return s;
  endfunction

  // apply a sign to a magnitude and saturate
  function automatic sat_t sat_mag(input logic neg, input logic [63:0] m);
    sat_t s;
    s.ov = 1'b0;
    if (neg) begin
      if (m > 64'h0000_0000_8000_0000) begin
        s.ov  = 1'b1;
        s.val = 32'h8000_0000;
      end else begin
        s.val = ~m[31:0] + 32'd1;
      end
    end else begin
      if (m > 64'h0000_0000_7fff_ffff) begin
        s.ov  = 1'b1;
        s.val = 32'h7fff_ffff;
      end else begin
        s.val = m[31:0];
      end
    end
    return s;
  endfunction

  // one restoring division step: returns {quotient bit, new remainder}
  function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nb,
                                           input logic [31:0] d);
    logic [32:0] t;
    logic [32:0] diff;
    t    = {rem, nb};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {1'b1, diff[31:0]};
    end
    return {1'b0, t[31:0]};
  endfunction

endpackage

/* rtl/vec3_arith_unit.sv */
// pipelined three-component fixed-point vector arithmetic unit
//
// items arrive on the item channel (item_valid / item_stall) carrying a mode,
// two Q16.16 vectors and a scalar; one result per item leaves on the res
// channel (res_valid / res_stall) with the vector result, the scalar result
// and the div_zero and overflow flags.
// the pipeline has 85 register stages: four for operand prep, multiply and
// sums, 32 for the square root (one root bit per stage) and 48 for the
// quotient (one bit per stage, three dividers side by side), then the
// output register. it takes one item per cycle in every mode unless
// a stalled result freezes the pipeline.
// while res_stall holds a waiting result, the whole pipeline freezes and
// item_stall goes high; nothing is dropped or repeated.
// reset clears all stage valid bits; the pipeline then accepts at once.
module vec3_arith_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [3:0]         mode,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  input  logic signed [31:0] scalar_in,
  output logic               res_valid,
  input  logic               res_stall,
  output logic signed [31:0] res_x,
  output logic signed [31:0] res_y,
  output logic signed [31:0] res_z,
  output logic signed [31:0] res_scalar,
  output logic               div_zero,
  output logic               overflow
);

  localparam int QW = v3au_pkg::QW;
  localparam int RS = v3au_pkg::ROOT_STEPS;
  localparam int FB = v3au_pkg::FRAC_BITS;

  logic adv;
  assign adv        = !(res_valid && res_stall);
  assign item_stall = !adv;

  // ---------------- stage a: add/sub, operand select ----------------
  logic [2:0][31:0] av, bv;
  assign av = {a_z, a_y, a_x};
  assign bv = {b_z, b_y, b_x};

  v3au_pkg::sat_t   sd [3];
  logic [2:0][31:0] dm;
  v3au_pkg::carry_t ca_next, ca;
  logic [2:0][31:0] ma_next, mb_next, ma, mb;
  logic [2:0]       pn_next, pn;
  logic             va;

  always_comb begin
    ca_next      = '0;
    ca_next.mode = v3au_pkg::mode_t'(mode);
    ca_next.smag = v3au_pkg::mag32(scalar_in);
    ca_next.sneg = scalar_in[31];
    ca_next.dz   = (ca_next.mode == v3au_pkg::MODE_DIV) && (scalar_in == 32'd0);
    for (int i = 0; i < 3; i++) begin
      if (ca_next.mode == v3au_pkg::MODE_ADD) begin
        sd[i] = v3au_pkg::sat_sum({av[i][31], av[i]} + {bv[i][31], bv[i]});
      end else begin
        sd[i] = v3au_pkg::sat_sum({av[i][31], av[i]} - {bv[i][31], bv[i]});
      end
      dm[i]           = v3au_pkg::mag32(sd[i].val);
      ca_next.nmag[i] = v3au_pkg::mag32(av[i]);
      ca_next.nneg[i] = av[i][31];
      ma_next[i]      = ca_next.nmag[i];
      mb_next[i]      = ca_next.nmag[i];
      pn_next[i]      = 1'b0;
      case (ca_next.mode)
        v3au_pkg::MODE_ADD, v3au_pkg::MODE_SUB: begin
          ca_next.res[i] = sd[i].val;
          ca_next.ov     = ca_next.ov | sd[i].ov;
        end
        v3au_pkg::MODE_SCALE: begin
          mb_next[i] = ca_next.smag;
          pn_next[i] = av[i][31] ^ scalar_in[31];
        end
        v3au_pkg::MODE_DOT: begin
          mb_next[i] = v3au_pkg::mag32(bv[i]);
          pn_next[i] = av[i][31] ^ bv[i][31];
        end
        v3au_pkg::MODE_DIST, v3au_pkg::MODE_DIST2: begin
          ma_next[i] = dm[i];
          mb_next[i] = dm[i];
          ca_next.ov = ca_next.ov | sd[i].ov;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ca <= ca_next;
      ma <= ma_next;
      mb <= mb_next;
      pn <= pn_next;
    end
  end

  // ---------------- stage b: products ----------------
  v3au_pkg::carry_t cb;
  logic [2:0][63:0] pb;
  logic [2:0]       pnb;
  logic             vb;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (adv) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cb  <= ca;
      pnb <= pn;
      for (int i = 0; i < 3; i++) begin
        pb[i] <= {32'd0, ma[i]} * {32'd0, mb[i]};
      end
    end
  end

  // ---------------- stage c: sums, scale results ----------------
  v3au_pkg::carry_t cc_next, cc;
  v3au_pkg::sat_t   ss [3];
  logic [63:0]      pos_next, neg_next, sq_next, pos, neg, sqc;
  logic             vc;

  always_comb begin
    cc_next  = cb;
    pos_next = '0;
    neg_next = '0;
    sq_next  = pb[0] + pb[1] + pb[2];
    for (int i = 0; i < 3; i++) begin
      if (pnb[i]) begin
        neg_next = neg_next + pb[i];
      end else begin
        pos_next = pos_next + pb[i];
      end
      ss[i] = v3au_pkg::sat_mag(pnb[i], pb[i] >> FB);
      if (cb.mode == v3au_pkg::MODE_SCALE) begin
        cc_next.res[i] = ss[i].val;
        cc_next.ov     = cc_next.ov | ss[i].ov;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (adv) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cc  <= cc_next;
      pos <= pos_next;
      neg <= neg_next;
      sqc <= sq_next;
    end
  end

  // ---------------- stage d: dot and squared length ----------------
  v3au_pkg::carry_t cd_next, cd;
  v3au_pkg::sat_t   sdot, slen2;
  logic [63:0]      dpn, dnp, sqd;
  logic             vd;

  always_comb begin
    cd_next = cc;
    dpn     = pos - neg;
    dnp     = neg - pos;
    if (pos >= neg) begin
      sdot = v3au_pkg::sat_mag(1'b0, dpn >> FB);
    end else begin
      sdot = v3au_pkg::sat_mag(1'b1, dnp >> FB);
    end
    slen2 = v3au_pkg::sat_mag(1'b0, sqc >> FB);
    case (cc.mode)
      v3au_pkg::MODE_DOT: begin
        cd_next.scl = sdot.val;
        cd_next.ov  = cc.ov | sdot.ov;
      end
      v3au_pkg::MODE_LEN2, v3au_pkg::MODE_DIST2: begin
        cd_next.scl = slen2.val;
        cd_next.ov  = cc.ov | slen2.ov;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (adv) begin
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cd  <= cd_next;
      sqd <= sqc;
    end
  end

  // ---------------- square root: one result bit per stage ----------------
  logic             vs [RS];
  v3au_pkg::carry_t cs [RS];
  logic [63:0]      sn [RS];
  logic [63:0]      sr [RS];

  for (genvar k = 0; k < RS; k++) begin : g_root
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic             v_pre;
    v3au_pkg::carry_t c_pre;
    logic [63:0]      n_pre, r_pre, t, n_nx, r_nx;

    if (k == 0) begin : g_first
      assign v_pre = vd;
      assign c_pre = cd;
      assign n_pre = sqd;
      assign r_pre = '0;
    end else begin : g_rest
      assign v_pre = vs[k-1];
      assign c_pre = cs[k-1];
      assign n_pre = sn[k-1];
      assign r_pre = sr[k-1];
    end

    always_comb begin
      t = r_pre + BIT;
      if (n_pre >= t) begin
        n_nx = n_pre - t;
        r_nx = (r_pre >> 1) + BIT;
      end else begin
        n_nx = n_pre;
        r_nx = r_pre >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k] <= 1'b0;
      end else if (adv) begin
        vs[k] <= v_pre;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cs[k] <= c_pre;
        sn[k] <= n_nx;
        sr[k] <= r_nx;
      end
    end
  end

  // ---------------- division: one quotient bit per stage ----------------
  logic                 vq   [QW];
  v3au_pkg::carry_t     cq   [QW];
  logic [2:0][31:0]     qrem [QW];
  logic [2:0][QW-1:0]   qdv  [QW];
  logic [2:0][QW-1:0]   qq   [QW];
  logic [31:0]          qd   [QW];

  v3au_pkg::carry_t   ci;
  logic [2:0][QW-1:0] dv_init;
  logic [31:0]        d_init;

  always_comb begin
    ci      = cs[RS-1];
    ci.root = sr[RS-1][31:0];
    if ((ci.mode == v3au_pkg::MODE_NORM) && (ci.root == 32'd0)) begin
      ci.dz = 1'b1;
    end
    d_init = (ci.mode == v3au_pkg::MODE_DIV) ? ci.smag : ci.root;
    for (int i = 0; i < 3; i++) begin
      dv_init[i] = {ci.nmag[i], {FB{1'b0}}};
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic               v_pre;
    v3au_pkg::carry_t   c_pre;
    logic [2:0][31:0]   rem_pre, rem_nx;
    logic [2:0][QW-1:0] dv_pre, q_pre, q_nx;
    logic [31:0]        d_pre;
    logic [2:0][32:0]   st;

    if (j == 0) begin : g_first
      assign v_pre   = vs[RS-1];
      assign c_pre   = ci;
      assign rem_pre = '0;
      assign dv_pre  = dv_init;
      assign q_pre   = '0;
      assign d_pre   = d_init;
    end else begin : g_rest
      assign v_pre   = vq[j-1];
      assign c_pre   = cq[j-1];
      assign rem_pre = qrem[j-1];
      assign dv_pre  = qdv[j-1];
      assign q_pre   = qq[j-1];
      assign d_pre   = qd[j-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        st[i]     = v3au_pkg::div_step(rem_pre[i], dv_pre[i][QW-1], d_pre);
        rem_nx[i] = st[i][31:0];
        q_nx[i]   = {q_pre[i][QW-2:0], st[i][32]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[j] <= 1'b0;
      end else if (adv) begin
        vq[j] <= v_pre;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cq[j]   <= c_pre;
        qrem[j] <= rem_nx;
        qq[j]   <= q_nx;
        qd[j]   <= d_pre;
        for (int i = 0; i < 3; i++) begin
          qdv[j][i] <= {dv_pre[i][QW-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- result assembly and output register ----------------
  v3au_pkg::carry_t cf;
  v3au_pkg::sat_t   qs [3];
  v3au_pkg::sat_t   qn [3];
  v3au_pkg::sat_t   ls;
  logic [2:0][31:0] r_next;
  logic [31:0]      sc_next;
  logic             dz_next, ov_next;

  always_comb begin
    cf      = cq[QW-1];
    r_next  = '0;
    sc_next = '0;
    dz_next = 1'b0;
    ov_next = 1'b0;
    ls      = v3au_pkg::sat_mag(1'b0, {32'd0, cf.root});
    for (int i = 0; i < 3; i++) begin
      qs[i] = v3au_pkg::sat_mag(cf.nneg[i] ^ cf.sneg, {{(64-QW){1'b0}}, qq[QW-1][i]});
      qn[i] = v3au_pkg::sat_mag(cf.nneg[i], {{(64-QW){1'b0}}, qq[QW-1][i]});
    end
    case (cf.mode)
      v3au_pkg::MODE_ADD, v3au_pkg::MODE_SUB, v3au_pkg::MODE_SCALE: begin
        r_next  = cf.res;
        ov_next = cf.ov;
      end
      v3au_pkg::MODE_DIV: begin
        dz_next = cf.dz;
        for (int i = 0; i < 3; i++) begin
          if (cf.dz) begin
            // zero divisor: saturate by numerator sign, zero stays zero
            if (cf.nmag[i] == 32'd0) begin
              r_next[i] = 32'd0;
            end else begin
              r_next[i] = cf.nneg[i] ? 32'h8000_0000 : 32'h7fff_ffff;
            end
          end else begin
            r_next[i] = qs[i].val;
            ov_next   = ov_next | qs[i].ov;
          end
        end
      end
      v3au_pkg::MODE_NORM: begin
        dz_next = cf.dz;
        if (!cf.dz) begin
          for (int i = 0; i < 3; i++) begin
            r_next[i] = qn[i].val;
            ov_next   = ov_next | qn[i].ov;
          end
        end
      end
      v3au_pkg::MODE_DOT, v3au_pkg::MODE_LEN2, v3au_pkg::MODE_DIST2: begin
        sc_next = cf.scl;
        ov_next = cf.ov;
      end
      v3au_pkg::MODE_LEN, v3au_pkg::MODE_DIST: begin
        sc_next = ls.val;
        ov_next = cf.ov | ls.ov;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= vq[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_x      <= r_next[0];
      res_y      <= r_next[1];
      res_z      <= r_next[2];
      res_scalar <= sc_next;
      div_zero   <= dz_next;
      overflow   <= ov_next;
    end
  end

endmodule
